// ----- design/hermite_transfer_function_table_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the transfer function table checker
// Implication helpers clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HERMITE_TRANSFER_FUNCTION_TABLE_ASSERT_SVH
`define HERMITE_TRANSFER_FUNCTION_TABLE_ASSERT_SVH

// same-cycle implication
`define HTF_ASSERT_IMP(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("htf assertion failed");

// next-cycle implication
`define HTF_ASSERT_NXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("htf assertion failed");

`endif

// ----- design/htf_pkg.sv -----
// ----------------------------------------------------------------------------
// htf_pkg
// Types, codes and constants shared by the transfer function table.
// ----------------------------------------------------------------------------
package htf_pkg;

  localparam int MAX_POINTS_DEF = 16;
  localparam int DIV_STEPS      = 16;
  localparam int MAC_STEPS      = 16;

  localparam logic [15:0] POS_END = 16'hFF00;   // 255.0 in Q8.8

  localparam logic [1:0] KIND_EVAL   = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;   // unused kind, no effect

  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_MISSING = 2'd2;

  typedef struct packed {
    logic [15:0] slope;
    logic [63:0] colour;
    logic [15:0] position;
  } entry_t;

  typedef enum logic [2:0] {
    RD_NONE, RD_K, RD_UP, RD_DN, RD_SEGA, RD_CLAMP
  } rd_sel_t;

  typedef enum logic [2:0] {
    WR_NONE, WR_INIT0, WR_INIT1, WR_SHIFT, WR_ITEM
  } wr_sel_t;

  typedef enum logic [4:0] {
    ST_INIT0, ST_INIT1, ST_IDLE, ST_DISPATCH, ST_SCAN_RD, ST_SCAN_CMP, ST_DECIDE,
    ST_SHU_CHK, ST_SHU_WR, ST_SHD_CHK, ST_SHD_WR, ST_EV_CLAMP, ST_EV_A, ST_EV_B,
    ST_DIV, ST_U2, ST_U3, ST_H, ST_MAC, ST_DRAIN, ST_FIN
  } state_t;

  typedef struct packed {
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    item_load;
    logic    k_inc;
    logic    scan_cmp;
    logic    j_from_count;
    logic    j_from_k;
    logic    j_dec;
    logic    j_inc;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    set_full;
    logic    set_missing;
    logic    load_a;
    logic    div_start;
    logic    div_step;
    logic    poly_u2;
    logic    poly_u3;
    logic    poly_h;
    logic    mac_step;
    logic    res_clamp;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       hit;
    logic       found;
    logic       k_zero;
    logic       k_end;
    logic       full;
    logic       cnt_zero;
    logic       j_eq_k;
    logic       j_last;
    logic       div_last;
    logic       mac_last;
  } stat_t;

endpackage

// ----- design/htf_if.sv -----
// ----------------------------------------------------------------------------
// htf_if
// Valid/ready channels for input items and result words.
// ----------------------------------------------------------------------------
interface htf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] position;
  logic [15:0] in_red;
  logic [15:0] in_green;
  logic [15:0] in_blue;
  logic [15:0] in_alpha;
  logic signed [15:0] in_slope;

  modport source (output valid, kind, position, in_red, in_green, in_blue, in_alpha,
                  in_slope, input ready);
  modport sink (input valid, kind, position, in_red, in_green, in_blue, in_alpha,
                in_slope, output ready);
endinterface

interface htf_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_red;
  logic [15:0] out_green;
  logic [15:0] out_blue;
  logic [15:0] out_alpha;
  logic [1:0]  status;
  logic [4:0]  point_total;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, status,
                  point_total, input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_alpha, status,
                point_total, output ready);
endinterface

// ----- design/htf_datapath.sv -----
// ----------------------------------------------------------------------------
// htf_datapath
// Point memory, scan/shift indexes, restoring divider, Hermite MAC, result regs.
// ----------------------------------------------------------------------------
module htf_datapath #(
  parameter int MAX_POINTS = htf_pkg::MAX_POINTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         kind,
  input  logic [15:0]        position,
  input  logic [15:0]        in_red,
  input  logic [15:0]        in_green,
  input  logic [15:0]        in_blue,
  input  logic [15:0]        in_alpha,
  input  logic signed [15:0] in_slope,
  input  htf_pkg::cmd_t      cmd,
  output htf_pkg::stat_t     stat,
  output logic [15:0]        out_red,
  output logic [15:0]        out_green,
  output logic [15:0]        out_blue,
  output logic [15:0]        out_alpha,
  output logic [1:0]         status,
  output logic [4:0]         point_total
);

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  logic [1:0]       kind_r;
  logic [15:0]      pos_r;
  logic [63:0]      col_r;
  logic [15:0]      slope_r;
  logic [CW-1:0]    count_r, k_r, j_r;
  logic             found_r;

  htf_pkg::entry_t  mem [MAX_POINTS];
  htf_pkg::entry_t  rdata_r, a_r, b_r, wr_data;
  logic [CW-1:0]    rd_idx, wr_idx;

  logic [16:0]      rem_r, rem2;
  logic [15:0]      den_r, q_r;
  logic [3:0]       dcnt_r;

  logic [31:0]      u2_r, u3_r;
  logic [47:0]      u3_full;
  logic signed [34:0] h_r [4];
  logic signed [34:0] s2, s3, su;

  logic [3:0]       mcnt_r, pcnt_r;
  logic             pv_r;
  logic signed [56:0] prod_r;
  logic signed [58:0] acc_r, sum;
  logic signed [21:0] x, diff, sl_a, sl_b;
  logic [15:0]      a_ch, b_ch;

  logic [63:0]      res_r;
  logic [1:0]       res_status_r;

  function automatic logic [15:0] round_sat(input logic signed [58:0] s);
    logic signed [59:0] v;
    v = 60'(s) + 60'sh0_8000_0000;
    if (v < 0) return 16'd0;
    if (v[59:48] != 12'd0) return 16'hFFFF;
    return v[47:32];
  endfunction

  // ---- memory ports ----
  always_comb begin
    case (cmd.rd_sel)
      htf_pkg::RD_K:     rd_idx = k_r;
      htf_pkg::RD_UP:    rd_idx = j_r - CW'(1);
      htf_pkg::RD_DN:    rd_idx = j_r + CW'(1);
      htf_pkg::RD_SEGA:  rd_idx = k_r - CW'(1);
      htf_pkg::RD_CLAMP: rd_idx = (k_r == '0) ? '0 : count_r - CW'(1);
      default:           rd_idx = '0;
    endcase
  end

  always_comb begin
    wr_data = rdata_r;
    case (cmd.wr_sel)
      htf_pkg::WR_INIT0: begin
        wr_idx  = '0;
        wr_data = '0;
      end
      htf_pkg::WR_INIT1: begin
        wr_idx           = CW'(1);
        wr_data.slope    = '0;
        wr_data.colour   = '1;
        wr_data.position = htf_pkg::POS_END;
      end
      htf_pkg::WR_SHIFT: wr_idx = j_r;
      htf_pkg::WR_ITEM: begin
        wr_idx           = k_r;
        wr_data.slope    = slope_r;
        wr_data.colour   = col_r;
        wr_data.position = pos_r;
      end
      default: wr_idx = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_sel != htf_pkg::WR_NONE) mem[wr_idx[IW-1:0]] <= wr_data;
    if (cmd.rd_sel != htf_pkg::RD_NONE) rdata_r <= mem[rd_idx[IW-1:0]];
  end

  // ---- item, indexes, count ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CW'(2);
    end else begin
      if (cmd.cnt_inc) count_r <= count_r + CW'(1);
      if (cmd.cnt_dec) count_r <= count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      kind_r       <= kind;
      pos_r        <= position;
      col_r        <= {in_alpha, in_blue, in_green, in_red};
      slope_r      <= in_slope;
      k_r          <= '0;
      found_r      <= 1'b0;
      res_r        <= '0;
      res_status_r <= htf_pkg::STATUS_DONE;
    end
    if (cmd.k_inc)        k_r <= k_r + CW'(1);
    if (cmd.scan_cmp)     found_r <= (rdata_r.position == pos_r);
    if (cmd.j_from_count) j_r <= count_r;
    if (cmd.j_from_k)     j_r <= k_r;
    if (cmd.j_dec)        j_r <= j_r - CW'(1);
    if (cmd.j_inc)        j_r <= j_r + CW'(1);
    if (cmd.set_full)     res_status_r <= htf_pkg::STATUS_FULL;
    if (cmd.set_missing)  res_status_r <= htf_pkg::STATUS_MISSING;
    if (cmd.res_clamp)    res_r <= rdata_r.colour;
    if (cmd.load_a)       a_r <= rdata_r;
    if (pv_r && (pcnt_r[1:0] == 2'd3)) res_r[pcnt_r[3:2]*16 +: 16] <= round_sat(sum);
  end

  // ---- u = (t - p0) * 2^16 / (p1 - p0), one quotient bit a cycle ----
  assign rem2 = {rem_r[15:0], 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      b_r    <= rdata_r;
      rem_r  <= {1'b0, pos_r - a_r.position};
      den_r  <= rdata_r.position - a_r.position;
      q_r    <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      if (rem2 >= {1'b0, den_r}) begin
        rem_r <= rem2 - {1'b0, den_r};
        q_r   <= {q_r[14:0], 1'b1};
      end else begin
        rem_r <= rem2;
        q_r   <= {q_r[14:0], 1'b0};
      end
      dcnt_r <= dcnt_r + 4'd1;
    end
  end

  // ---- weights ----
  assign u3_full = u2_r * q_r;
  assign s2 = $signed({3'b0, u2_r});
  assign s3 = $signed({3'b0, u3_r});
  assign su = $signed({3'b0, q_r, 16'b0});

  always_ff @(posedge clk) begin
    if (cmd.poly_u2) u2_r <= q_r * q_r;
    if (cmd.poly_u3) u3_r <= u3_full[47:16];
    if (cmd.poly_h) begin
      h_r[0] <= (s3 <<< 1) - s2 - (s2 <<< 1) + 35'sh1_0000_0000;
      h_r[1] <= s3 - (s2 <<< 1) + su;
      h_r[2] <= s3 - s2;
      h_r[3] <= s2 + (s2 <<< 1) - (s3 <<< 1);
    end
  end

  // ---- shared multiplier: four channels by four terms ----
  assign a_ch = a_r.colour[mcnt_r[3:2]*16 +: 16];
  assign b_ch = b_r.colour[mcnt_r[3:2]*16 +: 16];
  assign diff = $signed({6'b0, b_ch}) - $signed({6'b0, a_ch});
  assign sl_a = $signed({{2{a_r.slope[15]}}, a_r.slope, 4'b0});
  assign sl_b = $signed({{2{b_r.slope[15]}}, b_r.slope, 4'b0});

  always_comb begin
    case (mcnt_r[1:0])
      2'd0:    x = $signed({6'b0, a_ch});
      2'd1:    x = (mcnt_r[3:2] == 2'd3) ? sl_a : diff;
      2'd2:    x = (mcnt_r[3:2] == 2'd3) ? sl_b : diff;
      default: x = $signed({6'b0, b_ch});
    endcase
  end

  assign sum = ((pcnt_r[1:0] == 2'd0) ? 59'sd0 : acc_r) + 59'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= cmd.mac_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.poly_h) mcnt_r <= '0;
    if (cmd.mac_step) begin
      prod_r <= x * h_r[mcnt_r[1:0]];
      pcnt_r <= mcnt_r;
      mcnt_r <= mcnt_r + 4'd1;
    end
    if (pv_r) acc_r <= sum;
  end

  // ---- output word ----
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_red     <= res_r[15:0];
      out_green   <= res_r[31:16];
      out_blue    <= res_r[47:32];
      out_alpha   <= res_r[63:48];
      status      <= res_status_r;
      point_total <= 5'(count_r);
    end
  end

  always_comb begin
    stat.kind     = kind_r;
    stat.hit      = (kind_r == htf_pkg::KIND_EVAL) ? (rdata_r.position > pos_r)
                                                   : (rdata_r.position >= pos_r);
    stat.found    = found_r;
    stat.k_zero   = (k_r == '0);
    stat.k_end    = (k_r == count_r);
    stat.full     = (count_r == CW'(MAX_POINTS));
    stat.cnt_zero = (count_r == '0);
    stat.j_eq_k   = (j_r == k_r);
    stat.j_last   = ((j_r + CW'(1)) >= count_r);
    stat.div_last = (dcnt_r == 4'(htf_pkg::DIV_STEPS - 1));
    stat.mac_last = (mcnt_r == 4'(htf_pkg::MAC_STEPS - 1));
  end

endmodule

// ----- design/htf_ctrl.sv -----
// ----------------------------------------------------------------------------
// htf_ctrl
// Sequencer: scan, insert/remove shifting, evaluate steps, output handshake.
// ----------------------------------------------------------------------------
module htf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  htf_pkg::stat_t stat,
  output htf_pkg::cmd_t  cmd
);

  htf_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= htf_pkg::ST_INIT0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.rd_sel = htf_pkg::RD_NONE;
    cmd.wr_sel = htf_pkg::WR_NONE;
    in_ready   = 1'b0;
    case (state_r)
      htf_pkg::ST_INIT0: begin
        cmd.wr_sel = htf_pkg::WR_INIT0;
        state_nxt  = htf_pkg::ST_INIT1;
      end
      htf_pkg::ST_INIT1: begin
        cmd.wr_sel = htf_pkg::WR_INIT1;
        state_nxt  = htf_pkg::ST_IDLE;
      end
      htf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.item_load = 1'b1;
          state_nxt     = htf_pkg::ST_DISPATCH;
        end
      end
      htf_pkg::ST_DISPATCH: begin
        if (stat.kind == htf_pkg::KIND_EVAL && stat.cnt_zero) state_nxt = htf_pkg::ST_FIN;
        else if (stat.kind == htf_pkg::KIND_EVAL || stat.kind == htf_pkg::KIND_INSERT ||
                 stat.kind == htf_pkg::KIND_REMOVE) state_nxt = htf_pkg::ST_SCAN_RD;
        else state_nxt = htf_pkg::ST_FIN;
      end
      htf_pkg::ST_SCAN_RD: begin
        if (stat.k_end) begin
          state_nxt = htf_pkg::ST_DECIDE;
        end else begin
          cmd.rd_sel = htf_pkg::RD_K;
          state_nxt  = htf_pkg::ST_SCAN_CMP;
        end
      end
      htf_pkg::ST_SCAN_CMP: begin
        cmd.scan_cmp = 1'b1;
        if (stat.hit) begin
          state_nxt = htf_pkg::ST_DECIDE;
        end else begin
          cmd.k_inc = 1'b1;
          state_nxt = htf_pkg::ST_SCAN_RD;
        end
      end
      htf_pkg::ST_DECIDE: begin
        case (stat.kind)
          htf_pkg::KIND_EVAL: begin
            if (stat.k_zero || stat.k_end) begin
              cmd.rd_sel = htf_pkg::RD_CLAMP;
              state_nxt  = htf_pkg::ST_EV_CLAMP;
            end else begin
              cmd.rd_sel = htf_pkg::RD_SEGA;
              state_nxt  = htf_pkg::ST_EV_A;
            end
          end
          htf_pkg::KIND_INSERT: begin
            if (stat.found) begin
              cmd.wr_sel = htf_pkg::WR_ITEM;
              state_nxt  = htf_pkg::ST_FIN;
            end else if (stat.full) begin
              cmd.set_full = 1'b1;
              state_nxt    = htf_pkg::ST_FIN;
            end else begin
              cmd.j_from_count = 1'b1;
              state_nxt        = htf_pkg::ST_SHU_CHK;
            end
          end
          htf_pkg::KIND_REMOVE: begin
            if (!stat.found) begin
              cmd.set_missing = 1'b1;
              state_nxt       = htf_pkg::ST_FIN;
            end else begin
              cmd.j_from_k = 1'b1;
              state_nxt    = htf_pkg::ST_SHD_CHK;
            end
          end
          default: state_nxt = htf_pkg::ST_FIN;
        endcase
      end
      // open a slot: move entries up from the end down to the insert index
      htf_pkg::ST_SHU_CHK: begin
        if (stat.j_eq_k) begin
          cmd.wr_sel  = htf_pkg::WR_ITEM;
          cmd.cnt_inc = 1'b1;
          state_nxt   = htf_pkg::ST_FIN;
        end else begin
          cmd.rd_sel = htf_pkg::RD_UP;
          state_nxt  = htf_pkg::ST_SHU_WR;
        end
      end
      htf_pkg::ST_SHU_WR: begin
        cmd.wr_sel = htf_pkg::WR_SHIFT;
        cmd.j_dec  = 1'b1;
        state_nxt  = htf_pkg::ST_SHU_CHK;
      end
      // close the gap left by a removed point
      htf_pkg::ST_SHD_CHK: begin
        if (stat.j_last) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = htf_pkg::ST_FIN;
        end else begin
          cmd.rd_sel = htf_pkg::RD_DN;
          state_nxt  = htf_pkg::ST_SHD_WR;
        end
      end
      htf_pkg::ST_SHD_WR: begin
        cmd.wr_sel = htf_pkg::WR_SHIFT;
        cmd.j_inc  = 1'b1;
        state_nxt  = htf_pkg::ST_SHD_CHK;
      end
      htf_pkg::ST_EV_CLAMP: begin
        cmd.res_clamp = 1'b1;
        state_nxt     = htf_pkg::ST_FIN;
      end
      htf_pkg::ST_EV_A: begin
        cmd.load_a = 1'b1;
        cmd.rd_sel = htf_pkg::RD_K;
        state_nxt  = htf_pkg::ST_EV_B;
      end
      htf_pkg::ST_EV_B: begin
        cmd.div_start = 1'b1;
        state_nxt     = htf_pkg::ST_DIV;
      end
      htf_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_nxt = htf_pkg::ST_U2;
      end
      htf_pkg::ST_U2: begin
        cmd.poly_u2 = 1'b1;
        state_nxt   = htf_pkg::ST_U3;
      end
      htf_pkg::ST_U3: begin
        cmd.poly_u3 = 1'b1;
        state_nxt   = htf_pkg::ST_H;
      end
      htf_pkg::ST_H: begin
        cmd.poly_h = 1'b1;
        state_nxt  = htf_pkg::ST_MAC;
      end
      htf_pkg::ST_MAC: begin
        cmd.mac_step = 1'b1;
        if (stat.mac_last) state_nxt = htf_pkg::ST_DRAIN;
      end
      htf_pkg::ST_DRAIN: state_nxt = htf_pkg::ST_FIN;
      htf_pkg::ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = htf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = htf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.out_load)             out_valid_nxt = 1'b1;
  end

endmodule

// ----- design/hermite_transfer_function_table.sv -----
// ----------------------------------------------------------------------------
// hermite_transfer_function_table
// Sorted RGBA control point table with piecewise cubic Hermite evaluation.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     word
//  in_chan   in   valid/ready   kind, position, in_red..in_alpha, in_slope
//  out_chan  out  valid/ready   out_red..out_alpha, status, point_total
//
//  One item at a time. The scan reads the passed points one by one (one memory
//  read port); insert/remove shifting reads and writes each moved point; a
//  segment evaluate adds a 16-step divider plus 16 passes of one multiplier.
//  The shortest item is an unused kind or an evaluate of an empty table; the
//  longest is an evaluate in the last segment at 16 points.
//  After reset, the two default points are loaded before in_chan.ready.
//  A stalled output word holds; the next item is taken meanwhile.
// ----------------------------------------------------------------------------
module hermite_transfer_function_table #(
  parameter int MAX_POINTS = htf_pkg::MAX_POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  htf_in_if.sink      in_chan,
  htf_out_if.source   out_chan
);

  htf_pkg::cmd_t  cmd;
  htf_pkg::stat_t stat;

  htf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  htf_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .kind        (in_chan.kind),
    .position    (in_chan.position),
    .in_red      (in_chan.in_red),
    .in_green    (in_chan.in_green),
    .in_blue     (in_chan.in_blue),
    .in_alpha    (in_chan.in_alpha),
    .in_slope    (in_chan.in_slope),
    .cmd         (cmd),
    .stat        (stat),
    .out_red     (out_chan.out_red),
    .out_green   (out_chan.out_green),
    .out_blue    (out_chan.out_blue),
    .out_alpha   (out_chan.out_alpha),
    .status      (out_chan.status),
    .point_total (out_chan.point_total)
  );

endmodule

// ----- design/htf_checker.sv -----
// ----------------------------------------------------------------------------
// htf_checker
// Port-level checks on result words, bound to the top level.
// ----------------------------------------------------------------------------
`include "hermite_transfer_function_table_assert.svh"

module htf_checker #(
  parameter int MAX_POINTS = htf_pkg::MAX_POINTS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_red,
  input logic [15:0] out_green,
  input logic [15:0] out_blue,
  input logic [15:0] out_alpha,
  input logic [1:0]  status,
  input logic [4:0]  point_total
);

  `HTF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)

  // refused or missing items carry no colour
  `HTF_ASSERT_IMP(a_err_black, out_valid && (status != htf_pkg::STATUS_DONE),
                  {out_red, out_green, out_blue, out_alpha} == 64'd0)

  `HTF_ASSERT_IMP(a_full_total, out_valid && (status == htf_pkg::STATUS_FULL) &&
                  (MAX_POINTS < 32), point_total == 5'(MAX_POINTS))

  `HTF_ASSERT_IMP(a_total_max, out_valid && (MAX_POINTS < 32),
                  point_total <= 5'(MAX_POINTS))

endmodule

bind hermite_transfer_function_table htf_checker #(.MAX_POINTS(MAX_POINTS)) u_htf_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_red     (out_chan.out_red),
  .out_green   (out_chan.out_green),
  .out_blue    (out_chan.out_blue),
  .out_alpha   (out_chan.out_alpha),
  .status      (out_chan.status),
  .point_total (out_chan.point_total)
);

// ----- verif/htf_if.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// htf_if (testbench side)
// The channel interfaces are shared with the design folder; nothing is
// declared here.
// ----------------------------------------------------------------------------

// ----- verif/htf_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// htf_scoreboard
// Watches both channels, keeps a shadow point table, predicts each result
// word and compares it field by field against what the block returns.
// ----------------------------------------------------------------------------
module htf_scoreboard #(
  parameter int MAX_POINTS = htf_pkg::MAX_POINTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  htf_in_if         in_chan,
  htf_out_if        out_chan,
  output int        fail_count,
  output int        pending
);

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
    logic [1:0]  status;
    logic [4:0]  total;
  } result_t;

  int unsigned      tab_count;
  logic [15:0]      tab_pos   [MAX_POINTS];
  logic [63:0]      tab_rgba  [MAX_POINTS];
  logic [15:0]      tab_slope [MAX_POINTS];
  result_t          expected_words [$];

  assign pending = expected_words.size();

  function automatic longint chan_of(logic [63:0] c, int k);
    return longint'(c[16*k +: 16]);
  endfunction

  function automatic logic [15:0] blend(longint a, longint b, longint m0, longint m1,
                                        longint h0, longint h1, longint h2, longint h3);
    longint acc;
    acc = a * h0 + m0 * h1 + m1 * h2 + b * h3 + (longint'(1) << 31);
    if (acc < 0) return 16'd0;
    acc = acc >>> 32;
    return (acc > 65535) ? 16'hFFFF : acc[15:0];
  endfunction

  function automatic logic [63:0] shade_at(logic [15:0] t);
    int unsigned seg;
    longint num, den, u, u2, u3, h0, h1, h2, h3, a, b, s0, s1;
    logic [63:0] ca, cb, res;
    seg = 0;
    res = '0;
    if (tab_count == 0) return '0;
    if (tab_count == 1 || t < tab_pos[0]) return tab_rgba[0];
    if (t >= tab_pos[tab_count-1]) return tab_rgba[tab_count-1];
    for (int i = 0; i + 1 < tab_count; i++)
      if (t >= tab_pos[i] && t < tab_pos[i+1]) begin
        seg = i;
        break;
      end
    ca = tab_rgba[seg];
    cb = tab_rgba[seg+1];
    num = longint'(t - tab_pos[seg]) << 16;
    den = longint'(tab_pos[seg+1] - tab_pos[seg]);
    u = (den != 0) ? num / den : 0;
    if (u > 65535) u = 65535;
    u2 = u * u;
    u3 = (u2 * u) >>> 16;
    h0 = 2 * u3 - 3 * u2 + (longint'(1) << 32);
    h1 = u3 - 2 * u2 + (u << 16);
    h2 = u3 - u2;
    h3 = 3 * u2 - 2 * u3;
    for (int k = 0; k < 3; k++) begin
      a = chan_of(ca, k);
      b = chan_of(cb, k);
      res[16*k +: 16] = blend(a, b, b - a, b - a, h0, h1, h2, h3);
    end
    s0 = longint'($signed(tab_slope[seg])) * 16;
    s1 = longint'($signed(tab_slope[seg+1])) * 16;
    res[63:48] = blend(chan_of(ca, 3), chan_of(cb, 3), s0, s1, h0, h1, h2, h3);
    return res;
  endfunction

  // returns insertion index; hit set when the position already exists
  function automatic int unsigned locate(logic [15:0] p, output bit hit);
    hit = 0;
    for (int unsigned i = 0; i < tab_count; i++) begin
      if (tab_pos[i] == p) begin
        hit = 1;
        return i;
      end
      if (tab_pos[i] > p) return i;
    end
    return tab_count;
  endfunction

  function automatic result_t apply_word();
    result_t r;
    logic [63:0] c;
    int unsigned idx;
    bit hit;
    r = '0;
    c = '0;
    if (in_chan.kind == htf_pkg::KIND_EVAL) begin
      c = shade_at(in_chan.position);
    end else if (in_chan.kind == htf_pkg::KIND_INSERT) begin
      idx = locate(in_chan.position, hit);
      if (!hit) begin
        if (tab_count >= MAX_POINTS) r.status = htf_pkg::STATUS_FULL;
        else begin
          for (int unsigned j = tab_count; j > idx; j--) begin
            tab_pos[j] = tab_pos[j-1];
            tab_rgba[j] = tab_rgba[j-1];
            tab_slope[j] = tab_slope[j-1];
          end
          tab_count++;
        end
      end
      if (r.status == htf_pkg::STATUS_DONE && idx < MAX_POINTS) begin
        tab_pos[idx] = in_chan.position;
        tab_rgba[idx] = {in_chan.in_alpha, in_chan.in_blue, in_chan.in_green,
                         in_chan.in_red};
        tab_slope[idx] = in_chan.in_slope;
      end
    end else if (in_chan.kind == htf_pkg::KIND_REMOVE) begin
      idx = locate(in_chan.position, hit);
      if (!hit) r.status = htf_pkg::STATUS_MISSING;
      else begin
        for (int unsigned j = idx; j + 1 < tab_count; j++) begin
          tab_pos[j] = tab_pos[j+1];
          tab_rgba[j] = tab_rgba[j+1];
          tab_slope[j] = tab_slope[j+1];
        end
        tab_count--;
      end
    end
    r.red   = c[15:0];
    r.green = c[31:16];
    r.blue  = c[47:32];
    r.alpha = c[63:48];
    r.total = tab_count[4:0];
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("[%0t] mismatch %s: got %0d, want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    result_t w;
    if (!rst_n) begin
      fail_count = 0;
      tab_count = 2;
      for (int i = 0; i < MAX_POINTS; i++) begin
        tab_pos[i] = '0;
        tab_rgba[i] = '0;
        tab_slope[i] = '0;
      end
      tab_pos[1] = htf_pkg::POS_END;
      tab_rgba[1] = '1;
      expected_words.delete();
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_words.size() == 0) report("unexpected word", 1, 0);
        else begin
          w = expected_words.pop_front();
          if (out_chan.out_red !== w.red) report("red", out_chan.out_red, w.red);
          if (out_chan.out_green !== w.green)
            report("green", out_chan.out_green, w.green);
          if (out_chan.out_blue !== w.blue) report("blue", out_chan.out_blue, w.blue);
          if (out_chan.out_alpha !== w.alpha)
            report("alpha", out_chan.out_alpha, w.alpha);
          if (out_chan.status !== w.status) report("status", out_chan.status, w.status);
          if (out_chan.point_total !== w.total)
            report("point_total", out_chan.point_total, w.total);
        end
      end
      if (in_chan.valid && in_chan.ready) expected_words.push_back(apply_word());
    end
  end

endmodule

// ----- verif/tb_hermite_transfer_function_table.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hermite_transfer_function_table
// Drives insert, remove, evaluate and unused-kind words into the control point table with
// random gaps and output stalls; a checker module predicts every result.
// ----------------------------------------------------------------------------
module tb_hermite_transfer_function_table;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  int   send_idle_pct = 6;
  int   recv_idle_pct = 82;
  bit   hold_off = 0;

  htf_in_if  in_chan ();
  htf_out_if out_chan ();

  always #5 clk = ~clk;

  hermite_transfer_function_table #(.MAX_POINTS(htf_pkg::MAX_POINTS_DEF)) uut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source)
  );

  htf_scoreboard #(.MAX_POINTS(htf_pkg::MAX_POINTS_DEF)) chk (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .fail_count(fail_count), .pending(pending)
  );

  // receiver: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (!rst_n) out_chan.ready <= 1'b0;
    else out_chan.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_word(logic [1:0] kind, logic [15:0] pos,
                           logic [63:0] rgba, logic [15:0] slope);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid    <= 1'b1;
    in_chan.kind     <= kind;
    in_chan.position <= pos;
    in_chan.in_red   <= rgba[15:0];
    in_chan.in_green <= rgba[31:16];
    in_chan.in_blue  <= rgba[47:32];
    in_chan.in_alpha <= rgba[63:48];
    in_chan.in_slope <= slope;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  function automatic logic [63:0] rand_rgba();
    return {$urandom(), $urandom()};
  endfunction

  // positions mostly drawn from small grids so removes and replaces hit often
  function automatic logic [15:0] rand_pos();
    case ($urandom_range(3))
      0: return 16'($urandom());
      1: return 16'($urandom_range(15)) << 12;
      2: return 16'($urandom_range(63)) << 10;
      default: return 16'($urandom_range(20));
    endcase
  endfunction

  task automatic random_burst(int n);
    logic [1:0] k;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0, 1, 2:    k = htf_pkg::KIND_INSERT;
        3, 4:       k = htf_pkg::KIND_REMOVE;
        5:          k = htf_pkg::KIND_NONE;
        default:    k = htf_pkg::KIND_EVAL;
      endcase
      send_word(k, rand_pos(), rand_rgba(), 16'($urandom()));
    end
  endtask

  initial begin
    int cycles;
    in_chan.valid    <= 1'b0;
    in_chan.kind     <= htf_pkg::KIND_EVAL;
    in_chan.position <= '0;
    in_chan.in_red   <= '0;
    in_chan.in_green <= '0;
    in_chan.in_blue  <= '0;
    in_chan.in_alpha <= '0;
    in_chan.in_slope <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: default ramp, clamps, unused kind, empty and single point
    send_word(htf_pkg::KIND_EVAL, 16'h0000, '0, '0);
    send_word(htf_pkg::KIND_EVAL, 16'h7F80, '0, '0);
    send_word(htf_pkg::KIND_EVAL, 16'hFF00, '0, '0);
    send_word(htf_pkg::KIND_EVAL, 16'hFFFF, '0, '0);
    send_word(htf_pkg::KIND_NONE, 16'h1234, '1, '1);
    send_word(htf_pkg::KIND_INSERT, 16'h8000, '1, 16'h7FFF);
    send_word(htf_pkg::KIND_INSERT, 16'h4000, 64'h0000_FFFF_0000_FFFF, 16'h8000);
    send_word(htf_pkg::KIND_EVAL, 16'h2000, '0, '0);
    send_word(htf_pkg::KIND_EVAL, 16'h6000, '0, '0);
    send_word(htf_pkg::KIND_EVAL, 16'h0001, '0, '0);
    send_word(htf_pkg::KIND_REMOVE, 16'h0001, '0, '0);
    send_word(htf_pkg::KIND_REMOVE, 16'h0000, '0, '0);
    send_word(htf_pkg::KIND_EVAL, 16'h0000, '0, '0);
    send_word(htf_pkg::KIND_REMOVE, 16'h4000, '0, '0);
    send_word(htf_pkg::KIND_REMOVE, 16'h8000, '0, '0);
    send_word(htf_pkg::KIND_EVAL, 16'h0100, '0, '0);
    send_word(htf_pkg::KIND_REMOVE, 16'hFF00, '0, '0);
    send_word(htf_pkg::KIND_EVAL, 16'h0100, '0, '0);
    send_word(htf_pkg::KIND_REMOVE, 16'hFF00, '0, '0);
    send_word(htf_pkg::KIND_INSERT, 16'h0100, 64'h1234_5678_9ABC_DEF0, 16'h0FFF);
    send_word(htf_pkg::KIND_EVAL, 16'h0000, '0, '0);
    // fill to capacity, then refused insert and replace when full
    for (int i = 0; i < 17; i++)
      send_word(htf_pkg::KIND_INSERT, 16'(i * 16'h0F00 + 16'h0200), rand_rgba(),
                16'($urandom()));
    send_word(htf_pkg::KIND_INSERT, 16'hFFFF, '1, '1);
    send_word(htf_pkg::KIND_INSERT, 16'h0100, '0, 16'h8000);
    for (int i = 0; i < 6; i++) send_word(htf_pkg::KIND_EVAL, 16'($urandom()), '0, '0);

    random_burst(420);
    send_idle_pct = 82;
    recv_idle_pct = 6;
    random_burst(420);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_burst(220);

    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      random_burst(40);
    join
    in_chan.valid <= 1'b0;

    cycles = 0;
    while (pending != 0 && cycles < 20000) begin
      @(posedge clk);
      cycles++;
    end
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/htf_pkg.sv
design/htf_if.sv
design/htf_datapath.sv
design/htf_ctrl.sv
design/hermite_transfer_function_table.sv
design/htf_checker.sv
verif/htf_if.sv
verif/htf_checker.sv
verif/tb_hermite_transfer_function_table.sv
